// File: src/char_class_tokenizer_core_defines.svh
// Assertion macros shared by the tokenizer RTL.
`ifndef CHAR_CLASS_TOKENIZER_CORE_DEFINES_SVH
`define CHAR_CLASS_TOKENIZER_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define CCT_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tokenizer check failed");

// Next-cycle implication, checked outside reset.
`define CCT_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tokenizer check failed");

`endif

// File: src/cctok_pkg.sv
// ----------------------------------------------------------------------------
// cctok_pkg
// Class codes and the flag bundle passed from the step logic to the top level.
// ----------------------------------------------------------------------------
package cctok_pkg;

  localparam int ClassBits = 3;

  localparam logic [ClassBits-1:0] CLS_SPACE    = 3'd0;
  localparam logic [ClassBits-1:0] CLS_NUMBER   = 3'd1;
  localparam logic [ClassBits-1:0] CLS_CHARQ    = 3'd2;
  localparam logic [ClassBits-1:0] CLS_STRINGQ  = 3'd3;
  localparam logic [ClassBits-1:0] CLS_NOUN     = 3'd4;
  localparam logic [ClassBits-1:0] CLS_OPERATOR = 3'd5;
  localparam logic [ClassBits-1:0] CLS_BAD      = 3'd7;

  typedef struct packed {
    logic [ClassBits-1:0] byte_class;
    logic                 starts_token;
    logic                 closes_previous;
    logic [ClassBits-1:0] closed_class;
    logic                 bad_byte;
    logic                 finished;
  } tok_flags_t;

endpackage

// File: src/cctok_classify.sv
// ----------------------------------------------------------------------------
// cctok_classify
// Maps one source byte to its character class.
// ----------------------------------------------------------------------------
module cctok_classify
  import cctok_pkg::*;
(
  input  logic [7:0]           text_byte,
  output logic [ClassBits-1:0] byte_class
);

  always_comb begin
    if (text_byte inside {8'h20, 8'h09, 8'h0A, 8'h0D}) begin
      byte_class = CLS_SPACE;
    end else if (text_byte < 8'h20 || text_byte > 8'h7E) begin
      byte_class = CLS_BAD;
    end else if (text_byte inside {[8'h30:8'h39]}) begin
      byte_class = CLS_NUMBER;
    end else if (text_byte == 8'h27) begin
      byte_class = CLS_CHARQ;
    end else if (text_byte == 8'h22) begin
      byte_class = CLS_STRINGQ;
    end else if (text_byte inside {[8'h41:8'h5A], [8'h61:8'h7A], 8'h5F}) begin
      byte_class = CLS_NOUN;
    end else begin
      byte_class = CLS_OPERATOR;
    end
  end

endmodule

// File: src/cctok_step.sv
// ----------------------------------------------------------------------------
// cctok_step
// Next state and result flags for one byte: position update, token grouping,
// end of text and unknown byte handling.
// ----------------------------------------------------------------------------
module cctok_step
  import cctok_pkg::*;
#(
  parameter int POSITION_BITS = 16
) (
  input  logic [ClassBits-1:0]     open_class,
  input  logic [POSITION_BITS-1:0] line_count,
  input  logic [POSITION_BITS-1:0] column_count,
  input  logic                     halted,
  input  logic [7:0]               text_byte,
  input  logic                     end_of_text,
  output tok_flags_t               flags,
  output logic [7:0]               echo_byte,
  output logic [ClassBits-1:0]     open_class_next,
  output logic [POSITION_BITS-1:0] line_count_next,
  output logic [POSITION_BITS-1:0] column_count_next,
  output logic                     halted_next
);

  localparam logic [POSITION_BITS-1:0] PosMax = {POSITION_BITS{1'b1}};

  logic [ClassBits-1:0]   cls;
  logic [7:0]             eff_byte;
  logic [POSITION_BITS:0] line_inc;
  logic [POSITION_BITS:0] col_inc;
  logic [POSITION_BITS:0] col_tab;
  logic [POSITION_BITS-1:0] line_upd;
  logic [POSITION_BITS-1:0] col_upd;

  assign eff_byte = end_of_text ? 8'h00 : text_byte;

  cctok_classify u_classify (
    .text_byte  (eff_byte),
    .byte_class (cls)
  );

  // Saturating position arithmetic, one bit wider to see the carry.
  assign line_inc = {1'b0, line_count} + {{POSITION_BITS{1'b0}}, 1'b1};
  assign col_inc  = {1'b0, column_count} + {{POSITION_BITS{1'b0}}, 1'b1};
  assign col_tab  = {1'b0, column_count[POSITION_BITS-1:2], 2'b00}
                  + (POSITION_BITS+1)'(4);

  always_comb begin
    line_upd = line_count;
    if (eff_byte == 8'h0A) begin
      col_upd  = '0;
      line_upd = line_inc[POSITION_BITS] ? PosMax : line_inc[POSITION_BITS-1:0];
    end else if (eff_byte == 8'h09) begin
      col_upd = col_tab[POSITION_BITS] ? PosMax : col_tab[POSITION_BITS-1:0];
    end else begin
      col_upd = col_inc[POSITION_BITS] ? PosMax : col_inc[POSITION_BITS-1:0];
    end
  end

  always_comb begin
    flags             = '0;
    echo_byte         = eff_byte;
    open_class_next   = open_class;
    line_count_next   = line_upd;
    column_count_next = col_upd;
    halted_next       = halted;
    if (halted) begin
      // Inputs are ignored; position is held and every result says finished.
      flags.finished    = 1'b1;
      echo_byte         = 8'h00;
      line_count_next   = line_count;
      column_count_next = column_count;
    end else if (eff_byte == 8'h00) begin
      // End of text or NUL closes any open token and halts.
      flags.finished        = 1'b1;
      flags.closes_previous = (open_class != CLS_SPACE);
      flags.closed_class    = open_class;
      open_class_next       = CLS_SPACE;
      halted_next           = 1'b1;
    end else if (cls == CLS_BAD) begin
      flags.bad_byte  = 1'b1;
      open_class_next = CLS_SPACE;
      halted_next     = 1'b1;
    end else begin
      flags.byte_class      = cls;
      flags.starts_token    = (cls != CLS_SPACE) && (cls != open_class);
      flags.closes_previous = (open_class != CLS_SPACE) && (cls != open_class);
      flags.closed_class    = flags.closes_previous ? open_class : CLS_SPACE;
      open_class_next       = cls;
    end
  end

endmodule

// File: src/char_class_tokenizer_core.sv
// ----------------------------------------------------------------------------
// char_class_tokenizer_core
// Character-class lexer front end: one result per source byte.
// ----------------------------------------------------------------------------
// Source bytes enter on the s_ stream, one request per byte, and each byte
// gives exactly one result on the m_ stream. A byte is classed as whitespace,
// digit, char quote, string quote, identifier letter or underscore, or
// operator; runs of one class form a token, and each result says whether the
// byte starts a token and whether it closed the token before it. Line and
// column (tab stops of four) are the position after the byte and saturate at
// all ones. A NUL byte or s_tlast (end of text) closes the open token and
// raises m_tlast; an unknown byte raises m_tuser. After either the block is
// halted until reset and answers every further byte with m_tlast and the held
// position. While m_tready keeps up, the block takes one byte per cycle: a
// byte passes an input register, then the classification and position logic,
// and lands in the result register, which offers its result on m_tdata. The
// only loop is the token and position state, which closes within the one
// logic stage. A stalled result register still lets the input register take
// one more byte.
`include "char_class_tokenizer_core_defines.svh"

module char_class_tokenizer_core
  import cctok_pkg::*;
#(
  parameter int POSITION_BITS = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  // s_tdata: text_byte [7:0]
  input  logic [7:0] s_tdata,
  // s_tlast: end_of_text
  input  logic s_tlast,
  output logic m_tvalid,
  input  logic m_tready,
  // m_tdata from bit 0 up: byte_class (3), starts_token (1),
  // closes_previous (1), closed_class (3), echo_byte (8),
  // line_number (POSITION_BITS), column_number (POSITION_BITS), zero fill.
  output logic [(((16 + 2 * POSITION_BITS) + 7) / 8) * 8 - 1:0] m_tdata,
  // m_tuser: bad_byte
  output logic m_tuser,
  // m_tlast: finished
  output logic m_tlast
);

  localparam int TdataBits = (((16 + 2 * POSITION_BITS) + 7) / 8) * 8;

  // Input register.
  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_eot;

  // Tokenizer state.
  logic [ClassBits-1:0]     open_class;
  logic [POSITION_BITS-1:0] line_count;
  logic [POSITION_BITS-1:0] column_count;
  logic                     halted;

  // Result register.
  tok_flags_t               out_flags;
  logic [7:0]               out_echo;
  logic [POSITION_BITS-1:0] out_line;
  logic [POSITION_BITS-1:0] out_column;

  // Step logic outputs.
  tok_flags_t               step_flags;
  logic [7:0]               step_echo;
  logic [ClassBits-1:0]     open_class_next;
  logic [POSITION_BITS-1:0] line_count_next;
  logic [POSITION_BITS-1:0] column_count_next;
  logic                     halted_next;

  logic out_load;

  // The result register takes the buffered byte whenever it is empty or
  // being drained this cycle; the input register refills as it empties.
  assign out_load = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || out_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (out_load) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata;
      in_eot  <= s_tlast;
    end
  end

  cctok_step #(
    .POSITION_BITS (POSITION_BITS)
  ) u_step (
    .open_class        (open_class),
    .line_count        (line_count),
    .column_count      (column_count),
    .halted            (halted),
    .text_byte         (in_byte),
    .end_of_text       (in_eot),
    .flags             (step_flags),
    .echo_byte         (step_echo),
    .open_class_next   (open_class_next),
    .line_count_next   (line_count_next),
    .column_count_next (column_count_next),
    .halted_next       (halted_next)
  );

  // State advances exactly when a byte moves into the result register, so
  // bytes are processed strictly in arrival order.
  always_ff @(posedge clk) begin
    if (rst) begin
      open_class   <= CLS_SPACE;
      line_count   <= {{(POSITION_BITS-1){1'b0}}, 1'b1};
      column_count <= '0;
      halted       <= 1'b0;
      m_tvalid     <= 1'b0;
    end else begin
      if (out_load) begin
        open_class   <= open_class_next;
        line_count   <= line_count_next;
        column_count <= column_count_next;
        halted       <= halted_next;
        m_tvalid     <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_flags  <= step_flags;
      out_echo   <= step_echo;
      out_line   <= line_count_next;
      out_column <= column_count_next;
    end
  end

  assign m_tdata = TdataBits'({out_column, out_line, out_echo,
                               out_flags.closed_class, out_flags.closes_previous,
                               out_flags.starts_token, out_flags.byte_class});
  assign m_tuser = out_flags.bad_byte;
  assign m_tlast = out_flags.finished;

  // A halted block holds no open token and stays halted until reset.
  `CCT_ASSERT_NOW(a_halt_no_token, clk, rst, halted, open_class == CLS_SPACE)
  `CCT_ASSERT_NEXT(a_halt_sticks, clk, rst, halted, halted)
  // Lines are counted from one and never wrap to zero.
  `CCT_ASSERT_NOW(a_line_nonzero, clk, rst, 1'b1, line_count != '0)
  // A closed token always names its class, and a result is never both bad
  // and finished.
  `CCT_ASSERT_NOW(a_close_has_class, clk, rst, m_tvalid && out_flags.closes_previous,
                  out_flags.closed_class != CLS_SPACE)
  `CCT_ASSERT_NOW(a_bad_not_done, clk, rst, m_tvalid, !(m_tuser && m_tlast))

endmodule
